### rtl/core/attp_pkg.sv
`timescale 1ns / 1ps

package attp_pkg;

  // Fixed-point format and pixel coordinate width.
  localparam int unsigned FRAC_BITS  = 24;
  localparam int unsigned COORD_BITS = 12;

  // Shared multiplier: signed operands, full-width registered product.
  localparam int unsigned MUL_BITS  = 33;
  localparam int unsigned PROD_BITS = 2 * MUL_BITS;

  // Helper term divider. The quotient magnitude stays below |c|, where
  // c = 2.0 - 2a, and c is bounded by the 27-bit coefficient range.
  localparam int unsigned QUO_BITS  = ((FRAC_BITS + 1 > 27) ? FRAC_BITS + 1 : 27) + 1;
  localparam int unsigned C_BITS    = QUO_BITS + 1;
  localparam int unsigned DIVD_BITS = 32;
  localparam int unsigned DIVN_BITS = QUO_BITS + DIVD_BITS;

  // Pixel mapping: dt_raw = (width + height) * zoom, scaled by 2^(2F+2).
  localparam int unsigned DT_BITS   = 39;
  localparam int unsigned DT_SPLIT  = 20;
  localparam int unsigned PACC_BITS = 32 + DT_BITS;
  localparam int unsigned PIX_SHIFT = 2 * FRAC_BITS + 2;
  localparam int unsigned FL_BITS   = PACC_BITS - PIX_SHIFT;
  localparam int unsigned PX_BITS   = FL_BITS + 2;

  localparam logic [31:0]         Q_ONE  = 32'd1 << FRAC_BITS;
  localparam logic [PX_BITS-1:0]  PX_LIM = PX_BITS'(1) << COORD_BITS;

  localparam logic [3:0] WARMUP_MIN = 4'd8;
  localparam logic [3:0] WARMUP_MAX = 4'd15;

  typedef enum logic [2:0] {
    CFG_COEF_A       = 3'd0,
    CFG_COEF_B       = 3'd1,
    CFG_ZOOM         = 3'd2,
    CFG_FRAME_WIDTH  = 3'd3,
    CFG_FRAME_HEIGHT = 3'd4
  } cfg_index_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DT,
    ST_DT_SAVE,
    ST_PXL,
    ST_PXH,
    ST_PXF,
    ST_PXC,
    ST_PYH,
    ST_PYF,
    ST_PYC,
    ST_BY,
    ST_BY_Q,
    ST_XN,
    ST_XX,
    ST_XX_Q,
    ST_CU,
    ST_CU_D,
    ST_AX_Q,
    ST_DIV_WAIT,
    ST_W,
    ST_Y,
    ST_FIN
  } state_t;

endpackage

### rtl/core/attp_mul.sv
`timescale 1ns / 1ps

// Shared signed multiplier with a registered full-width product.
module attp_mul (
  input  logic                                  clk,
  input  logic signed [attp_pkg::MUL_BITS-1:0]  op_a,
  input  logic signed [attp_pkg::MUL_BITS-1:0]  op_b,
  output logic signed [attp_pkg::PROD_BITS-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

### rtl/core/attp_div.sv
`timescale 1ns / 1ps

// Restoring unsigned divider, one quotient bit per cycle.
// The caller guarantees that the quotient fits in QUO_BITS bits.
module attp_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [attp_pkg::DIVN_BITS-1:0]       dividend,
  input  logic [attp_pkg::DIVD_BITS-1:0]       divisor,
  output logic                                 busy,
  output logic [attp_pkg::QUO_BITS-1:0]        quotient
);

  localparam int unsigned CNT_W = $clog2(attp_pkg::QUO_BITS + 1);

  logic [attp_pkg::DIVD_BITS-1:0] rem;
  logic [attp_pkg::DIVD_BITS-1:0] dsr;
  logic [attp_pkg::QUO_BITS-1:0]  low;
  logic [CNT_W-1:0]               count;
  logic [attp_pkg::DIVD_BITS:0]   rem2;
  logic [attp_pkg::DIVD_BITS:0]   diff;
  logic                           ge;

  always_comb begin
    rem2 = {rem, low[attp_pkg::QUO_BITS-1]};
    diff = rem2 - {1'b0, dsr};
    ge   = (rem2 >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CNT_W'(attp_pkg::QUO_BITS);
    end else if (busy) begin
      count <= count - CNT_W'(1);
      if (count == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[attp_pkg::DIVN_BITS-1:attp_pkg::QUO_BITS];
      low <= dividend[attp_pkg::QUO_BITS-1:0];
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[attp_pkg::DIVD_BITS-1:0] : rem2[attp_pkg::DIVD_BITS-1:0];
      low <= {low[attp_pkg::QUO_BITS-2:0], ge};
    end
  end

  assign quotient = low;

endmodule

### rtl/core/attractor_point_plotter.sv
`timescale 1ns / 1ps

// Gumowski-Mira attractor point plotter in signed Q8.24 fixed point. Each item
// beat yields exactly one result beat. A load beat (command 0) sets the point
// from start_x/start_y, recomputes the helper term w and clears the warm-up
// count; its result is all zeros. A step beat (command 1) maps the current
// point to a pixel, reports plot when the pixel is inside the frame and at
// least nine steps have passed, and then advances the map. All arithmetic runs
// on one shared 33x33 multiplier and a restoring divider under a sequencer,
// so the block takes one item at a time and holds item_stall high while it
// works. The divider resolves one quotient bit of c*u/(1+u) per cycle. The
// result sits in an output register, so the next item beat is taken while a
// result still waits. Configuration registers are written through the cfg
// port (always ready) and must only change while the block is idle.
module attractor_point_plotter (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [2:0]                        cfg_index,
  input  logic [26:0]                       cfg_data,
  // Item channel.
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic                              command,
  input  logic signed [31:0]                start_x,
  input  logic signed [31:0]                start_y,
  input  logic [23:0]                       color,
  // Result channel.
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic                              plot,
  output logic [attp_pkg::COORD_BITS-1:0]   pixel_x,
  output logic [attp_pkg::COORD_BITS-1:0]   pixel_y,
  output logic [23:0]                       pixel_color
);

  // Truncate a product toward zero by FRAC_BITS, then saturate to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [attp_pkg::PROD_BITS-1:0] v);
    logic signed [attp_pkg::PROD_BITS-1:0] smax;
    logic signed [attp_pkg::PROD_BITS-1:0] smin;
    logic signed [31:0]                    res;
    smax = attp_pkg::PROD_BITS'(33'sh07FFFFFFF);
    smin = attp_pkg::PROD_BITS'(-33'sh080000000);
    if (v > smax) begin
      res = 32'sh7FFFFFFF;
    end else if (v < smin) begin
      res = 32'sh80000000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  function automatic logic signed [31:0] qmul(input logic signed [attp_pkg::PROD_BITS-1:0] p);
    logic [attp_pkg::PROD_BITS-1:0]        bias;
    logic [attp_pkg::PROD_BITS-1:0]        adj;
    logic signed [attp_pkg::PROD_BITS-1:0] sh;
    bias = p[attp_pkg::PROD_BITS-1] ?
           ((attp_pkg::PROD_BITS'(1) << attp_pkg::FRAC_BITS) - attp_pkg::PROD_BITS'(1)) : '0;
    adj  = $unsigned(p) + bias;
    sh   = $signed(adj) >>> attp_pkg::FRAC_BITS;
    return sat32(sh);
  endfunction

  // Pixel coordinate: half +/- (magnitude * dt_raw / 2^(2F+2)), truncated
  // toward zero. acc holds the exact magnitude product.
  function automatic logic signed [attp_pkg::PX_BITS-1:0] px_calc(
    input logic [attp_pkg::PACC_BITS-1:0] acc,
    input logic                           neg,
    input logic [11:0]                    half
  );
    logic [attp_pkg::FL_BITS-1:0]        fl;
    logic                                fr;
    logic signed [attp_pkg::PX_BITS-1:0] hl;
    logic signed [attp_pkg::PX_BITS-1:0] fle;
    logic signed [attp_pkg::PX_BITS-1:0] frs;
    logic signed [attp_pkg::PX_BITS-1:0] res;
    fl  = acc[attp_pkg::PACC_BITS-1:attp_pkg::PIX_SHIFT];
    fr  = |acc[attp_pkg::PIX_SHIFT-1:0];
    hl  = $signed(attp_pkg::PX_BITS'(half));
    fle = $signed(attp_pkg::PX_BITS'(fl));
    frs = $signed(attp_pkg::PX_BITS'(fr));
    if (!neg) begin
      res = hl + fle;
    end else if ((hl > fle) || ((hl == fle) && !fr)) begin
      res = hl - fle - frs;
    end else begin
      res = hl - fle;
    end
    return res;
  endfunction

  function automatic logic in_frame(input logic signed [attp_pkg::PX_BITS-1:0] p,
                                    input logic [12:0] size);
    logic [attp_pkg::PX_BITS-1:0] pu;
    pu = $unsigned(p);
    return !p[attp_pkg::PX_BITS-1] && (pu < attp_pkg::PX_BITS'(size)) &&
           (pu < attp_pkg::PX_LIM);
  endfunction

  // Configuration registers.
  logic signed [26:0] coef_a;
  logic signed [26:0] coef_b;
  logic [24:0]        zoom;
  logic [12:0]        frame_width;
  logic [12:0]        frame_height;

  // Map state.
  attp_pkg::state_t   state;
  attp_pkg::state_t   state_next;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] term_w;
  logic [3:0]         warmup_count;
  logic               step_cmd;

  // Working registers of the sequence.
  logic [attp_pkg::DT_BITS-1:0]    dt_raw;
  logic [attp_pkg::PACC_BITS-1:0]  pacc;
  logic signed [31:0]              qm;
  logic signed [31:0]              u_sq;
  logic signed [31:0]              t_old;
  logic                            c_neg;
  logic                            x_inside;
  logic [23:0]                     color_hold;
  logic                            pend_plot;
  logic [attp_pkg::COORD_BITS-1:0] pend_x;
  logic [attp_pkg::COORD_BITS-1:0] pend_y;
  logic [23:0]                     pend_color;

  // Shared units.
  logic signed [attp_pkg::MUL_BITS-1:0]  mul_a;
  logic signed [attp_pkg::MUL_BITS-1:0]  mul_b;
  logic signed [attp_pkg::PROD_BITS-1:0] prod;
  logic                                  div_start;
  logic                                  div_busy;
  logic [attp_pkg::DIVN_BITS-1:0]        div_dividend;
  logic [attp_pkg::DIVD_BITS-1:0]        div_divisor;
  logic [attp_pkg::QUO_BITS-1:0]         div_quot;

  // Derived values.
  logic signed [32:0]                  d_x;
  logic [32:0]                         nd_x;
  logic [31:0]                         mag_x;
  logic [31:0]                         mag_y;
  logic signed [attp_pkg::C_BITS-1:0]  c_val;
  logic [attp_pkg::PROD_BITS-1:0]      prod_abs;
  logic signed [attp_pkg::QUO_BITS:0]  frac_s;
  logic signed [attp_pkg::PX_BITS-1:0] px_val;
  logic                                plot_ok;
  logic                                item_take;
  logic                                result_load;

  assign cfg_ready   = 1'b1;
  assign item_take   = item_valid && !item_stall;
  assign result_load = (state == attp_pkg::ST_FIN) && (!result_valid || !result_stall);

  always_comb begin
    d_x      = $signed({point_x[31], point_x}) - $signed({1'b0, attp_pkg::Q_ONE});
    nd_x     = $unsigned(-d_x);
    mag_x    = d_x[32] ? nd_x[31:0] : $unsigned(d_x[31:0]);
    mag_y    = point_y[31] ? (~$unsigned(point_y) + 32'd1) : $unsigned(point_y);
    // c = 2.0 - 2a, kept exact.
    c_val    = $signed(attp_pkg::C_BITS'(1) << (attp_pkg::FRAC_BITS + 1)) -
               (attp_pkg::C_BITS'(coef_a) <<< 1);
    prod_abs = prod[attp_pkg::PROD_BITS-1] ? $unsigned(-prod) : $unsigned(prod);
    div_dividend = prod_abs[attp_pkg::DIVN_BITS-1:0];
    div_divisor  = attp_pkg::Q_ONE + $unsigned(u_sq);
    frac_s   = c_neg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
    // The pixel accumulator holds x at ST_PXC and y at ST_PYC.
    px_val   = (state == attp_pkg::ST_PYC) ?
               px_calc(pacc, point_y[31], frame_height[12:1]) :
               px_calc(pacc, d_x[32], frame_width[12:1]);
    plot_ok  = x_inside && in_frame(px_val, frame_height) && (warmup_count > attp_pkg::WARMUP_MIN);
  end

  attp_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  attp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    case (state)
      attp_pkg::ST_IDLE: begin
        if (item_take) begin
          state_next = command ? attp_pkg::ST_DT : attp_pkg::ST_XX;
        end
      end
      attp_pkg::ST_DT:       state_next = attp_pkg::ST_DT_SAVE;
      attp_pkg::ST_DT_SAVE:  state_next = attp_pkg::ST_PXL;
      attp_pkg::ST_PXL:      state_next = attp_pkg::ST_PXH;
      attp_pkg::ST_PXH:      state_next = attp_pkg::ST_PXF;
      attp_pkg::ST_PXF:      state_next = attp_pkg::ST_PXC;
      attp_pkg::ST_PXC:      state_next = attp_pkg::ST_PYH;
      attp_pkg::ST_PYH:      state_next = attp_pkg::ST_PYF;
      attp_pkg::ST_PYF:      state_next = attp_pkg::ST_PYC;
      attp_pkg::ST_PYC:      state_next = attp_pkg::ST_BY;
      attp_pkg::ST_BY:       state_next = attp_pkg::ST_BY_Q;
      attp_pkg::ST_BY_Q:     state_next = attp_pkg::ST_XN;
      attp_pkg::ST_XN:       state_next = attp_pkg::ST_XX;
      attp_pkg::ST_XX:       state_next = attp_pkg::ST_XX_Q;
      attp_pkg::ST_XX_Q:     state_next = attp_pkg::ST_CU;
      attp_pkg::ST_CU:       state_next = attp_pkg::ST_CU_D;
      attp_pkg::ST_CU_D:     state_next = attp_pkg::ST_AX_Q;
      attp_pkg::ST_AX_Q:     state_next = attp_pkg::ST_DIV_WAIT;
      attp_pkg::ST_DIV_WAIT: begin
        if (!div_busy) begin
          state_next = attp_pkg::ST_W;
        end
      end
      attp_pkg::ST_W:        state_next = step_cmd ? attp_pkg::ST_Y : attp_pkg::ST_FIN;
      attp_pkg::ST_Y:        state_next = attp_pkg::ST_FIN;
      attp_pkg::ST_FIN: begin
        if (result_load) begin
          state_next = attp_pkg::ST_IDLE;
        end
      end
      default:               state_next = attp_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: unit controls and handshake.
  always_comb begin
    item_stall = (state != attp_pkg::ST_IDLE);
    div_start  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      attp_pkg::ST_DT: begin
        mul_a = $signed(attp_pkg::MUL_BITS'({1'b0, frame_width} + {1'b0, frame_height}));
        mul_b = $signed(attp_pkg::MUL_BITS'(zoom));
      end
      attp_pkg::ST_PXL: begin
        mul_a = $signed(attp_pkg::MUL_BITS'(mag_x));
        mul_b = $signed(attp_pkg::MUL_BITS'(dt_raw[attp_pkg::DT_SPLIT-1:0]));
      end
      attp_pkg::ST_PXH: begin
        mul_a = $signed(attp_pkg::MUL_BITS'(mag_x));
        mul_b = $signed(attp_pkg::MUL_BITS'(dt_raw[attp_pkg::DT_BITS-1:attp_pkg::DT_SPLIT]));
      end
      attp_pkg::ST_PXC: begin
        mul_a = $signed(attp_pkg::MUL_BITS'(mag_y));
        mul_b = $signed(attp_pkg::MUL_BITS'(dt_raw[attp_pkg::DT_SPLIT-1:0]));
      end
      attp_pkg::ST_PYH: begin
        mul_a = $signed(attp_pkg::MUL_BITS'(mag_y));
        mul_b = $signed(attp_pkg::MUL_BITS'(dt_raw[attp_pkg::DT_BITS-1:attp_pkg::DT_SPLIT]));
      end
      attp_pkg::ST_BY: begin
        mul_a = attp_pkg::MUL_BITS'(coef_b);
        mul_b = attp_pkg::MUL_BITS'(point_y);
      end
      attp_pkg::ST_XX: begin
        mul_a = attp_pkg::MUL_BITS'(point_x);
        mul_b = attp_pkg::MUL_BITS'(point_x);
      end
      attp_pkg::ST_CU: begin
        mul_a = attp_pkg::MUL_BITS'(c_val);
        mul_b = attp_pkg::MUL_BITS'(u_sq);
      end
      attp_pkg::ST_CU_D: begin
        div_start = 1'b1;
        mul_a     = attp_pkg::MUL_BITS'(coef_a);
        mul_b     = attp_pkg::MUL_BITS'(point_x);
      end
      default: begin
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_a       <= 27'sd1677722;
      coef_b       <= 27'sd16609444;
      zoom         <= 25'd1677722;
      frame_width  <= 13'd640;
      frame_height <= 13'd300;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        attp_pkg::CFG_COEF_A:       coef_a       <= $signed(cfg_data);
        attp_pkg::CFG_COEF_B:       coef_b       <= $signed(cfg_data);
        attp_pkg::CFG_ZOOM:         zoom         <= cfg_data[24:0];
        attp_pkg::CFG_FRAME_WIDTH:  frame_width  <= cfg_data[12:0];
        attp_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data[12:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer state and map state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= attp_pkg::ST_IDLE;
      point_x      <= '0;
      point_y      <= '0;
      term_w       <= '0;
      warmup_count <= '0;
      step_cmd     <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        attp_pkg::ST_IDLE: begin
          if (item_take) begin
            step_cmd <= command;
            if (!command) begin
              point_x      <= start_x;
              point_y      <= start_y;
              warmup_count <= '0;
            end
          end
        end
        attp_pkg::ST_XN: begin
          point_x <= sat32(attp_pkg::PROD_BITS'(qm) + attp_pkg::PROD_BITS'(term_w));
        end
        attp_pkg::ST_W: begin
          term_w <= sat32(attp_pkg::PROD_BITS'(qm) + attp_pkg::PROD_BITS'(frac_s));
        end
        attp_pkg::ST_Y: begin
          point_y <= sat32(attp_pkg::PROD_BITS'(term_w) - attp_pkg::PROD_BITS'(t_old));
          if (warmup_count < attp_pkg::WARMUP_MAX) begin
            warmup_count <= warmup_count + 4'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers; each is written before it is read in a sequence.
  always_ff @(posedge clk) begin
    case (state)
      attp_pkg::ST_IDLE: begin
        if (item_take) begin
          t_old      <= point_x;
          color_hold <= color;
          pend_plot  <= 1'b0;
          pend_x     <= '0;
          pend_y     <= '0;
          pend_color <= '0;
        end
      end
      attp_pkg::ST_DT_SAVE: dt_raw <= prod[attp_pkg::DT_BITS-1:0];
      attp_pkg::ST_PXH,
      attp_pkg::ST_PYH:     pacc <= attp_pkg::PACC_BITS'($unsigned(prod));
      attp_pkg::ST_PXF,
      attp_pkg::ST_PYF: begin
        pacc <= pacc + {prod[attp_pkg::PACC_BITS-attp_pkg::DT_SPLIT-1:0],
                        {attp_pkg::DT_SPLIT{1'b0}}};
      end
      attp_pkg::ST_PXC: begin
        x_inside <= in_frame(px_val, frame_width);
        pend_x   <= px_val[attp_pkg::COORD_BITS-1:0];
      end
      attp_pkg::ST_PYC: begin
        pend_plot  <= plot_ok;
        pend_x     <= plot_ok ? pend_x : '0;
        pend_y     <= plot_ok ? px_val[attp_pkg::COORD_BITS-1:0] : '0;
        pend_color <= plot_ok ? color_hold : '0;
      end
      attp_pkg::ST_BY_Q,
      attp_pkg::ST_AX_Q:    qm <= qmul(prod);
      attp_pkg::ST_XX_Q:    u_sq <= qmul(prod);
      attp_pkg::ST_CU_D:    c_neg <= prod[attp_pkg::PROD_BITS-1];
      default: begin
      end
    endcase
  end

  // Output register; a new result is loaded once the previous beat is gone.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      plot        <= pend_plot;
      pixel_x     <= pend_x;
      pixel_y     <= pend_y;
      pixel_color <= pend_color;
    end
  end

`ifndef SYNTHESIS
  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == attp_pkg::ST_IDLE) |-> !div_busy)
    else $error("divider busy while the sequencer is idle");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> item_stall)
    else $error("item accepted while a previous item is still in work");

  a_no_plot_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !plot) |-> (pixel_x == '0 && pixel_y == '0 && pixel_color == '0))
    else $error("result without plot carries nonzero fields");

  a_fin_waits_for_slot: assert property (@(posedge clk) disable iff (rst)
    (state == attp_pkg::ST_FIN && result_valid && result_stall) |=>
    (state == attp_pkg::ST_FIN && result_valid))
    else $error("finished result overwrote a stalled result beat");
`endif

endmodule

### dv/attractor_point_plotter_tb.sv
`timescale 1ns / 1ps

// Self-checking testbench for the attractor point plotter.
//
// A short directed pass runs first. It walks a list of item beats at the reset
// configuration: steps straight after reset, loads at the corners of the
// coordinate range, and one orbit long enough to leave warm-up and reach a
// saturated step count. Rows whose result is obvious carry a typed-in
// expectation. Every other beat is checked against a cycle-free model of the
// map. That model keeps its own orbit state and its own copy of the
// configuration.
//
// After that, the run goes through a series of configuration phases. They
// include the register extremes, a zero-sized frame, a frame larger than the
// coordinate range, a zero zoom, raw bit patterns outside the documented
// ranges, and a few random settings. Within each phase, most of the traffic is
// a load near the origin followed by a long run of steps, so that orbits pass
// warm-up and land on the attractor. The rest is loads anywhere in the 32-bit
// range, which drive the saturation paths, and short runs of steps.
// Both channels idle and stall at random.
module attractor_point_plotter_tb;

  typedef enum bit {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } mira_cmd_t;

  // One result beat, in port order.
  typedef struct packed {
    logic                            plot;
    logic [attp_pkg::COORD_BITS-1:0] px;
    logic [attp_pkg::COORD_BITS-1:0] py;
    logic [23:0]                     rgb;
  } pixel_beat_t;

  // One row of the directed pass. When known is set, the result is the
  // typed-in beat rather than the model's.
  typedef struct packed {
    mira_cmd_t   cmd;
    logic [31:0] sx;
    logic [31:0] sy;
    logic [23:0] rgb;
    bit          known;
    pixel_beat_t beat;
  } dir_row_t;

  typedef struct packed {
    logic [26:0] a;
    logic [26:0] b;
    logic [26:0] zoom;
    logic [26:0] width;
    logic [26:0] height;
  } mira_setting_t;

  localparam longint FX_ONE    = longint'(attp_pkg::Q_ONE);
  localparam longint S32_TOP   = 64'sd2147483647;
  localparam longint S32_BOT   = -S32_TOP - 1;
  localparam longint COORD_LIM = longint'(1) << attp_pkg::COORD_BITS;

  localparam int NUM_PHASES      = 10;
  localparam int NUM_FIXED       = 6;
  localparam int ITEMS_PER_PHASE = 180;
  localparam int IDLE_TAIL       = 8;
  localparam int END_TAIL        = 60;
  localparam int CYCLE_LIMIT     = 1_000_000;

  // All item beats below use the reset configuration. The load results and
  // the first nine steps after each load are all-zero by definition.
  localparam dir_row_t DIR_ROWS [24] = '{
    '{CMD_STEP, 32'h0000_0000, 32'h0000_0000, 24'hFF_FFFF, 1'b1, '0},
    '{CMD_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF, 1'b1, '0},
    '{CMD_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b1, '0},
    '{CMD_LOAD, 32'h8000_0000, 32'h8000_0000, 24'h00_0000, 1'b1, '0},
    '{CMD_STEP, 32'h0000_0000, 32'h0000_0000, 24'h00_0000, 1'b1, '0},
    '{CMD_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 24'hA5_5A5A, 1'b1, '0},
    '{CMD_LOAD, 32'h0100_0000, 32'h0000_0000, 24'h00_0000, 1'b1, '0},
    '{CMD_STEP, 32'h0000_0000, 32'h0000_0000, 24'hFF_FFFF, 1'b1, '0},
    '{CMD_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'h00_0000, 1'b1, '0},
    '{CMD_STEP, 32'h0000_0000, 32'h0000_0000, 24'hFF_FFFF, 1'b1, '0},
    '{CMD_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'h00_0000, 1'b1, '0},
    '{CMD_STEP, 32'h0000_0000, 32'h0000_0000, 24'hFF_FFFF, 1'b1, '0},
    '{CMD_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'h00_0000, 1'b1, '0},
    '{CMD_STEP, 32'h0000_0000, 32'h0000_0000, 24'hFF_FFFF, 1'b1, '0},
    '{CMD_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'h00_0000, 1'b1, '0},
    '{CMD_STEP, 32'h0000_0000, 32'h0000_0000, 24'hFF_FFFF, 1'b1, '0},
    '{CMD_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b0, '0},
    '{CMD_STEP, 32'h0000_0000, 32'h0000_0000, 24'h00_0000, 1'b0, '0},
    '{CMD_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b0, '0},
    '{CMD_STEP, 32'h0000_0000, 32'h0000_0000, 24'h12_3456, 1'b0, '0},
    '{CMD_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b0, '0},
    '{CMD_STEP, 32'h0000_0000, 32'h0000_0000, 24'h80_0001, 1'b0, '0},
    '{CMD_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b0, '0},
    '{CMD_STEP, 32'h0000_0000, 32'h0000_0000, 24'h7F_FFFE, 1'b0, '0}
  };

  // The settings of phases 1 to 6, in the order a, b, zoom, width, height.
  // The first two phases are plain and extreme. After them come a zero zoom
  // on a 1x1 frame, a zero-sized frame with the widest zoom pattern, and a
  // frame beyond the coordinate range with raw 27-bit coefficient patterns.
  localparam mira_setting_t FIXED_SETTINGS [NUM_FIXED] = '{
    '{27'h7B_1EB8, 27'hEE_147B, 27'd1677722, 27'd640, 27'd480},
    '{27'd33554432, 27'h600_0000, 27'd16777216, 27'd4096, 27'd4096},
    '{27'h600_0000, 27'd33554432, 27'd0, 27'd1, 27'd1},
    '{27'd1677722, 27'd16609444, 27'h1FF_FFFF, 27'd0, 27'd0},
    '{27'h400_0000, 27'h3FF_FFFF, 27'd131072, 27'h1FFF, 27'h1FFF},
    '{27'd4194304, 27'd16441671, 27'd838861, 27'd1024, 27'd768}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [26:0] cfg_data  = '0;

  logic        item_valid = 1'b0;
  logic        item_stall;
  logic        command    = 1'b0;
  logic [31:0] start_x    = '0;
  logic [31:0] start_y    = '0;
  logic [23:0] color      = '0;

  logic                            result_valid;
  logic                            result_stall = 1'b0;
  logic                            plot;
  logic [attp_pkg::COORD_BITS-1:0] pixel_x;
  logic [attp_pkg::COORD_BITS-1:0] pixel_y;
  logic [23:0]                     pixel_color;

  attractor_point_plotter dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .command      (command),
    .start_x      (start_x),
    .start_y      (start_y),
    .color        (color),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .plot         (plot),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .pixel_color  (pixel_color)
  );

  always #5 clk = ~clk;

  // The model's copy of the configuration, at its reset values.
  longint      gm_a      = 1677722;
  longint      gm_b      = 16609444;
  logic [24:0] gm_zoom   = 25'd1677722;
  logic [12:0] gm_width  = 13'd640;
  logic [12:0] gm_height = 13'd300;

  // The model's orbit: current point, helper term w and the steps since load.
  longint     orbit_x   = 0;
  longint     orbit_y   = 0;
  longint     orbit_w   = 0;
  logic [3:0] orbit_age = '0;

  pixel_beat_t pending_pixels [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  bit          sender_calm    = 1'b0;

  function automatic longint clamp32(longint v);
    if (v > S32_TOP) return S32_TOP;
    if (v < S32_BOT) return S32_BOT;
    return v;
  endfunction

  // Full product, truncated toward zero back to Q8.24, then saturated.
  function automatic longint fx_mul(longint p, longint q);
    longint prod;
    prod = p * q;
    if (prod < 0) return clamp32(-((-prod) >>> attp_pkg::FRAC_BITS));
    return clamp32(prod >>> attp_pkg::FRAC_BITS);
  endfunction

  // w = a*x + c*x^2/(1+x^2), where c = 2 - 2a is held exactly and the
  // quotient is truncated toward zero.
  function automatic longint helper_term(longint x);
    longint c, u;
    c = 2 * FX_ONE - 2 * gm_a;
    u = fx_mul(x, x);
    return clamp32(fx_mul(gm_a, x) + (c * u) / (FX_ONE + u));
  endfunction

  // trunc(d * dt_raw / 2^(2F+2) + half), with the product kept exact.
  function automatic longint pixel_coord(longint d, logic [127:0] dt_raw, longint half);
    logic [127:0] mag, prod;
    longint       whole;
    bit           frac;
    mag   = (d < 0) ? 128'(-d) : 128'(d);
    prod  = mag * dt_raw;
    whole = longint'(prod >> attp_pkg::PIX_SHIFT);
    frac  = prod[attp_pkg::PIX_SHIFT-1:0] != '0;
    if (d >= 0) return half + whole;
    // A negative offset that leaves the sum at or above zero rounds down.
    // One that goes below zero rounds up toward zero.
    if (half > whole || (half == whole && !frac)) return half - whole - (frac ? 1 : 0);
    return half - whole;
  endfunction

  // Applies one item beat to the model's orbit and returns its result beat.
  function automatic pixel_beat_t plot_point(mira_cmd_t cmd, logic [31:0] sx,
                                             logic [31:0] sy, logic [23:0] rgb);
    pixel_beat_t  beat;
    logic [127:0] dt_raw;
    longint       px, py, prev_x;
    beat = '0;
    if (cmd == CMD_LOAD) begin
      orbit_x   = longint'($signed(sx));
      orbit_y   = longint'($signed(sy));
      orbit_w   = helper_term(orbit_x);
      orbit_age = '0;
      return beat;
    end
    dt_raw = (128'(gm_width) + 128'(gm_height)) * 128'(gm_zoom);
    px = pixel_coord(orbit_x - FX_ONE, dt_raw, longint'(gm_width >> 1));
    py = pixel_coord(orbit_y, dt_raw, longint'(gm_height >> 1));
    // A pixel has to fall inside the frame and inside the coordinate range,
    // and the orbit must be past warm-up.
    if (px >= 0 && px < longint'(gm_width) && px < COORD_LIM &&
        py >= 0 && py < longint'(gm_height) && py < COORD_LIM &&
        orbit_age > attp_pkg::WARMUP_MIN) begin
      beat = '{1'b1, attp_pkg::COORD_BITS'(px), attp_pkg::COORD_BITS'(py), rgb};
    end
    prev_x  = orbit_x;
    orbit_x = clamp32(fx_mul(gm_b, orbit_y) + orbit_w);
    orbit_w = helper_term(orbit_x);
    orbit_y = clamp32(orbit_w - prev_x);
    if (orbit_age < attp_pkg::WARMUP_MAX) orbit_age = orbit_age + 4'd1;
    return beat;
  endfunction

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // A Q8.24 coordinate within +/-8.0, which keeps most orbits bounded.
  function automatic logic [31:0] near_origin();
    return 32'($urandom_range(0, 32'h1000_0000)) - 32'h0800_0000;
  endfunction

  task automatic note_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("[%0d] %s", cycle_count, msg);
  endtask

  // Presents one item beat and holds it until the block takes it. At the
  // accepting edge, the expected result is queued. Valid stays high into the
  // next beat when no gap follows, so it is never dropped and raised again
  // in the same step.
  task automatic send_item(mira_cmd_t cmd, logic [31:0] sx, logic [31:0] sy,
                           logic [23:0] rgb, bit known = 1'b0,
                           pixel_beat_t known_beat = '0);
    pixel_beat_t modeled;
    int unsigned gap;
    item_valid <= 1'b1;
    command    <= cmd;
    start_x    <= sx;
    start_y    <= sy;
    color      <= rgb;
    do @(posedge clk); while (item_stall);
    modeled = plot_point(cmd, sx, sy, rgb);
    pending_pixels.push_back(known ? known_beat : modeled);
    gap = sender_calm ? 0 : gap_len();
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every queued result has come back. The
  // extra cycles let the block settle before the configuration changes.
  task automatic settle();
    item_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  // Writes one register and mirrors the write into the model. Valid is
  // dropped for one cycle after each write.
  task automatic write_reg(attp_pkg::cfg_index_t idx, logic [26:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      attp_pkg::CFG_COEF_A:       gm_a = longint'($signed(value));
      attp_pkg::CFG_COEF_B:       gm_b = longint'($signed(value));
      attp_pkg::CFG_ZOOM:         gm_zoom = value[24:0];
      attp_pkg::CFG_FRAME_WIDTH:  gm_width = value[12:0];
      attp_pkg::CFG_FRAME_HEIGHT: gm_height = value[12:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: the stall toggles between stretches of free flow and stall
  // bursts of random length. Free stretches are never empty, so
  // the stall is assigned at most once in a time step.
  initial begin : result_pacing
    int unsigned flow, hold;
    forever begin
      @(posedge clk);
      result_stall <= 1'b0;
      flow = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
      repeat (flow) @(posedge clk);
      hold = gap_len();
      if (hold != 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
    end
  end

  // Result checker. Each accepted result beat is compared field by field
  // with the oldest queued expectation.
  always @(posedge clk) begin
    pixel_beat_t want, got;
    if (!rst && result_valid && !result_stall) begin
      got = {plot, pixel_x, pixel_y, pixel_color};
      if (pending_pixels.size() == 0) begin
        note_failure($sformatf("result beat with nothing expected: %h", got));
      end else begin
        want = pending_pixels.pop_front();
        if (got.plot !== want.plot)
          note_failure($sformatf("plot: expected %0d, got %0d", want.plot, got.plot));
        if (got.px !== want.px)
          note_failure($sformatf("pixel_x: expected %0d, got %0d", want.px, got.px));
        if (got.py !== want.py)
          note_failure($sformatf("pixel_y: expected %0d, got %0d", want.py, got.py));
        if (got.rgb !== want.rgb)
          note_failure($sformatf("pixel_color: expected %h, got %h", want.rgb, got.rgb));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("attractor_point_plotter_tb: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    mira_setting_t s;
    int unsigned   sent, burst, r;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (DIR_ROWS[i])
      send_item(DIR_ROWS[i].cmd, DIR_ROWS[i].sx, DIR_ROWS[i].sy, DIR_ROWS[i].rgb,
                DIR_ROWS[i].known, DIR_ROWS[i].beat);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // Phase 0 keeps the reset configuration. Each later phase waits for the
      // block to go idle and then writes all five registers.
      if (ph != 0) begin
        settle();
        if (ph <= NUM_FIXED) begin
          s = FIXED_SETTINGS[ph-1];
        end else begin
          s.a      = 27'($urandom_range(0, 33554432)) - 27'd16777216;
          s.b      = 27'($urandom_range(15099494, 16777216));
          s.zoom   = 27'($urandom_range(83886, 8388608));
          s.width  = 27'($urandom_range(1, 4096));
          s.height = 27'($urandom_range(1, 4096));
        end
        write_reg(attp_pkg::CFG_COEF_A, s.a);
        write_reg(attp_pkg::CFG_COEF_B, s.b);
        write_reg(attp_pkg::CFG_ZOOM, s.zoom);
        write_reg(attp_pkg::CFG_FRAME_WIDTH, s.width);
        write_reg(attp_pkg::CFG_FRAME_HEIGHT, s.height);
      end

      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        r = $urandom_range(0, 9);
        sender_calm = ($urandom_range(0, 3) == 0);
        if (r < 7) begin
          // A well-formed orbit: a load near the origin, then enough steps
          // to leave warm-up and trace the attractor.
          send_item(CMD_LOAD, near_origin(), near_origin(), 24'($urandom()));
          burst = $urandom_range(6, 40);
          sent++;
        end else if (r < 9) begin
          // A load anywhere in the full range, which mostly saturates.
          send_item(CMD_LOAD, $urandom(), $urandom(), 24'($urandom()));
          burst = $urandom_range(0, 12);
          sent++;
        end else begin
          // A few more steps on whatever orbit is current.
          burst = $urandom_range(1, 3);
        end
        // On steps, start_x and start_y carry random content the block ignores.
        repeat (burst) send_item(CMD_STEP, $urandom(), $urandom(), 24'($urandom()));
        sent += burst;
        if ($urandom_range(0, 24) == 0) settle();
      end
    end

    settle();
    repeat (END_TAIL) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("attractor_point_plotter_tb: PASS");
    end else begin
      $display("attractor_point_plotter_tb: FAIL");
    end
    $finish;
  end

endmodule
